// File: hw/rtl/cov_pkg.sv
// Package with shared types, constants and the pair-address helper function of the co-visibility selector.
`timescale 1ns / 1ps
package cov_pkg;

	localparam int MAX_CAMS = 64;
	localparam int CAM_W = 6;
	localparam int CNT_W = 32;
	localparam int NCAM_W = 7;
	localparam int MINS_W = 16;
	localparam int DEPTH = MAX_CAMS * MAX_CAMS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_CAMS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SHARED = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [CAM_W-1:0] ref_cam;
		logic [CAM_W-1:0] target_cam;
	} cov_item_t;

	typedef struct packed {
		logic found;
		logic [CAM_W-1:0] cam_index;
		logic [CNT_W-1:0] shared_count;
		logic last;
	} cov_result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic clr_we;
		logic add_rd;
		logic add_wr;
		logic q_init;
		logic scan_issue;
		logic decide;
		logic emit_final;
	} cov_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] cmd;
		logic clr_done;
		logic add_ok;
		logic query_ok;
		logic scan_end;
		logic qualify;
		logic pass_last;
	} cov_stat_t;

	// Table address of a camera pair: smaller camera is the row.
	function automatic logic [ADDR_W-1:0] pair_addr(input logic [CAM_W-1:0] a,
			input logic [CAM_W-1:0] b);
		logic [CAM_W-1:0] lo;
		logic [CAM_W-1:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return ADDR_W'(int'(lo) * MAX_CAMS + int'(hi));
	endfunction

endpackage

// File: hw/rtl/cov_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cov_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/cov_datapath.sv
// Datapath: configuration registers, count table, row scan and result registers.
`timescale 1ns / 1ps
module cov_datapath (
	input logic clk,
	input logic arst_n,
	input cov_pkg::cov_item_t item,
	input logic cfg_wr,
	input logic [cov_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cov_pkg::CFG_DATA_W-1:0] cfg_data,
	input cov_pkg::cov_cmd_t cmd,
	output cov_pkg::cov_stat_t stat,
	output logic result_valid,
	output cov_pkg::cov_result_t result
);
	import cov_pkg::*;

	logic [NCAM_W-1:0] num_cams_q;
	logic [NCAM_W-1:0] want_count_q;
	logic [MINS_W-1:0] min_shared_q;
	cov_item_t item_q;
	logic [ADDR_W-1:0] clr_q;
	logic [NCAM_W-1:0] scan_q;
	logic rd_vld_s1;
	logic [CAM_W-1:0] rd_idx_s1;
	logic have_best_q;
	logic [CNT_W-1:0] best_c_q;
	logic [CAM_W-1:0] best_i_q;
	logic [MAX_CAMS-1:0] taken_q;
	logic [NCAM_W-1:0] rank_q;
	logic pend_vld_q;
	logic [CAM_W-1:0] pend_i_q;
	logic [CNT_W-1:0] pend_c_q;
	logic result_valid_q;
	cov_result_t result_q;

	logic [NCAM_W-1:0] n_cams;
	logic [NCAM_W-1:0] limit;
	logic [ADDR_W-1:0] add_addr;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [CNT_W-1:0] wdata;
	logic [CNT_W-1:0] rdata;
	logic we;
	logic better;
	logic qualify;

	// Effective camera count and number of ranks a query considers.
	assign n_cams = (num_cams_q > NCAM_W'(MAX_CAMS)) ? NCAM_W'(MAX_CAMS) : num_cams_q;
	assign limit = (want_count_q < n_cams) ? want_count_q : n_cams;
	assign add_addr = pair_addr(item_q.ref_cam, item_q.target_cam);

	// Table port selection.
	assign raddr = cmd.scan_issue ? pair_addr(item_q.ref_cam, scan_q[CAM_W-1:0]) : add_addr;
	assign we = cmd.clr_we | cmd.add_wr;
	assign waddr = cmd.clr_we ? clr_q : add_addr;
	assign wdata = cmd.clr_we ? '0 : ((rdata == '1) ? rdata : rdata + CNT_W'(1));

	cov_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_table (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// A returning count beats the best so far; the ascending scan settles ties.
	assign better = rd_vld_s1 && !taken_q[rd_idx_s1] && (!have_best_q || rdata > best_c_q);
	assign qualify = best_c_q > CNT_W'(min_shared_q);

	// Status toward the controller.
	always_comb begin
		stat.cmd = item_q.cmd;
		stat.clr_done = (clr_q == ADDR_W'(DEPTH - 1));
		stat.add_ok = (NCAM_W'(item_q.ref_cam) < n_cams) && (NCAM_W'(item_q.target_cam) < n_cams);
		stat.query_ok = (NCAM_W'(item_q.ref_cam) < n_cams) && (limit != '0);
		stat.scan_end = (scan_q == n_cams - NCAM_W'(1));
		stat.qualify = qualify;
		stat.pass_last = (rank_q + NCAM_W'(1) == limit);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cams_q <= NCAM_W'(64);
			want_count_q <= NCAM_W'(10);
			min_shared_q <= MINS_W'(20);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_NUM_CAMS: num_cams_q <= cfg_data[NCAM_W-1:0];
				REG_WANT_COUNT: want_count_q <= cfg_data[NCAM_W-1:0];
				REG_MIN_SHARED: min_shared_q <= cfg_data[MINS_W-1:0];
				default: ;
			endcase
		end
	end

	// Payload of the accepted beat.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
	end

	// Clearing sweep, scan control and selection state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			scan_q <= '0;
			rd_vld_s1 <= 1'b0;
			have_best_q <= 1'b0;
			taken_q <= '0;
			rank_q <= '0;
			pend_vld_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_we) begin
				clr_q <= stat.clr_done ? '0 : clr_q + ADDR_W'(1);
			end
			rd_vld_s1 <= cmd.scan_issue;
			if (cmd.scan_issue) begin
				scan_q <= scan_q + NCAM_W'(1);
			end
			if (better) begin
				have_best_q <= 1'b1;
			end
			result_valid_q <= 1'b0;
			if (cmd.q_init) begin
				taken_q <= '0;
				rank_q <= '0;
				pend_vld_q <= 1'b0;
				scan_q <= '0;
				have_best_q <= 1'b0;
			end
			if (cmd.decide && qualify) begin
				taken_q[best_i_q] <= 1'b1;
				rank_q <= rank_q + NCAM_W'(1);
				pend_vld_q <= 1'b1;
				scan_q <= '0;
				have_best_q <= 1'b0;
				result_valid_q <= pend_vld_q;
			end
			if (cmd.emit_final) begin
				result_valid_q <= 1'b1;
			end
		end
	end

	// Best candidate, pending result and the result register.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[CAM_W-1:0];
		if (better) begin
			best_c_q <= rdata;
			best_i_q <= rd_idx_s1;
		end
		if (cmd.decide && qualify) begin
			pend_i_q <= best_i_q;
			pend_c_q <= best_c_q;
			result_q.found <= 1'b1;
			result_q.cam_index <= pend_i_q;
			result_q.shared_count <= pend_c_q;
			result_q.last <= 1'b0;
		end
		if (cmd.emit_final) begin
			result_q.found <= pend_vld_q;
			result_q.cam_index <= pend_vld_q ? pend_i_q : '0;
			result_q.shared_count <= pend_vld_q ? pend_c_q : '0;
			result_q.last <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// File: hw/rtl/cov_ctrl.sv
// Controller state machine that sequences clear, add and query commands.
`timescale 1ns / 1ps
module cov_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cov_pkg::cov_stat_t stat,
	output cov_pkg::cov_cmd_t cmd
);
	import cov_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_ADD_RD,
		S_ADD_WR,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_FINAL
	} state_t;

	state_t state_q;

	// State register; the table is swept clean after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (stat.clr_done) state_q <= S_IDLE;
				S_IDLE: if (start) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					unique case (stat.cmd)
						CMD_CLEAR: state_q <= S_CLEAR;
						CMD_ADD: state_q <= stat.add_ok ? S_ADD_RD : S_IDLE;
						CMD_QUERY: state_q <= stat.query_ok ? S_SCAN : S_FINAL;
						default: state_q <= S_IDLE;
					endcase
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: state_q <= S_IDLE;
				S_SCAN: if (stat.scan_end) state_q <= S_DRAIN;
				S_DRAIN: state_q <= S_DECIDE;
				S_DECIDE: state_q <= (stat.qualify && !stat.pass_last) ? S_SCAN : S_FINAL;
				S_FINAL: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath commands decoded from the state.
	always_comb begin
		cmd = '0;
		cmd.latch = (state_q == S_IDLE) && start;
		cmd.clr_we = (state_q == S_CLEAR);
		cmd.add_rd = (state_q == S_ADD_RD);
		cmd.add_wr = (state_q == S_ADD_WR);
		cmd.q_init = (state_q == S_DISPATCH);
		cmd.scan_issue = (state_q == S_SCAN);
		cmd.decide = (state_q == S_DECIDE);
		cmd.emit_final = (state_q == S_FINAL);
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: hw/rtl/covisibility_top_k_selector_core.sv
// Top level of the co-visibility top-k selector: controller plus datapath.
// Clear runs from an accepted beat through dispatch, then clears one table
// entry per cycle; after reset the same sweep runs with busy high.
// Add steps through accept, dispatch, read and write-back.
// A query makes one table read per camera per rank pass;
// results come one per strobe and the receiver cannot stall them.
// Configuration registers reset to num_cams 64, want_count 10, min_shared 20.
`timescale 1ns / 1ps
module covisibility_top_k_selector_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cov_pkg::cov_item_t item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [cov_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cov_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic result_valid,
	output cov_pkg::cov_result_t result
);
	import cov_pkg::*;

	cov_cmd_t cmd;
	cov_stat_t stat;

	// Configuration beats are always taken.
	assign cfg_ready = 1'b1;

	cov_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.stat(stat),
		.cmd(cmd)
	);

	cov_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cfg_wr(cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.stat(stat),
		.result_valid(result_valid),
		.result(result)
	);

endmodule
